@@ hdl/tcs_pkg.sv @@
package tcs_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int HISTORY_LINES = 256;

  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int SCR_DEPTH = ROWS * COLUMNS;
  localparam int SCR_AW    = $clog2(SCR_DEPTH);
  localparam int HIST_DEPTH = HISTORY_LINES * COLUMNS;
  localparam int HIST_AW   = $clog2(HIST_DEPTH);
  localparam int LINE_W    = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
  localparam int CNT_W     = $clog2(HISTORY_LINES + 1);

  localparam logic [2:0] FN_PRINT  = 3'd0;
  localparam logic [2:0] FN_POKE   = 3'd1;
  localparam logic [2:0] FN_UP     = 3'd2;
  localparam logic [2:0] FN_DOWN   = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;
  localparam logic [2:0] FN_READ   = 3'd5;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] BLANK_ATTR_RESET = 8'd15;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_EXEC,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_RD_CAP,
    ST_FIN
  } state_e;

endpackage

@@ hdl/tcs_if.sv @@
interface tcs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] ch;
  logic [7:0] attr;
  logic [6:0] col;
  logic [5:0] row;
  logic       at_cursor;

  modport source (output valid, func, ch, attr, col, row, at_cursor, input ready);
  modport sink (input valid, func, ch, attr, col, row, at_cursor, output ready);
endinterface

interface tcs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic [8:0] view_offset;
  logic [8:0] history_fill;
  logic       coord_error;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, view_offset,
                  history_fill, coord_error, input ready);
  modport sink (input valid, cursor_col, cursor_row, cell_char, cell_attr, view_offset,
                history_fill, coord_error, output ready);
endinterface

@@ hdl/tcs_ram.sv @@
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/tcs_addr.sv @@
module tcs_addr (
  input  logic [tcs_pkg::ROW_W-1:0]  top_i,
  input  logic [tcs_pkg::ROW_W-1:0]  row_i,
  input  logic [tcs_pkg::COL_W-1:0]  col_i,
  output logic [tcs_pkg::SCR_AW-1:0] addr_o
);

  logic [tcs_pkg::ROW_W:0]   sum;
  logic [tcs_pkg::ROW_W-1:0] prow;

  always_comb begin
    sum = {1'b0, top_i} + {1'b0, row_i};
    if (int'(sum) >= tcs_pkg::ROWS) begin
      prow = tcs_pkg::ROW_W'(int'(sum) - tcs_pkg::ROWS);
    end else begin
      prow = sum[tcs_pkg::ROW_W-1:0];
    end
    addr_o = tcs_pkg::SCR_AW'(int'(prow) * tcs_pkg::COLUMNS + int'(col_i));
  end

endmodule

@@ hdl/text_console_with_scrollback.sv @@
// Text console engine with an 80 x 25 screen and a 256 line scrollback ring. Each input word
// performs one operation and returns one result word. A new word is accepted only after the
// result of the last one is loaded into the output register; a view read of a stored cell
// first passes through a read capture state. A print that runs past the last cell moves the
// top row into history one cell at a time through the single screen memory port. Clear
// sweeps all 2000 screen cells, one per cycle. After reset the same sweep zeroes the screen,
// so the block accepts no word until the sweep ends; writes of the blank attribute are taken
// at any time.
module text_console_with_scrollback (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  tcs_in_if.sink     in_i,
  tcs_out_if.source  out_o
);

  tcs_pkg::state_e state_q, state_d;
  logic [tcs_pkg::SCR_AW-1:0] cnt_q, cnt_d;
  logic zero_q, zero_d;
  logic [2:0] func_q;
  logic [7:0] ch_q, attr_q;
  logic [6:0] col_q;
  logic [5:0] row_q;
  logic atc_q;
  logic [7:0] dflt_q;
  logic [tcs_pkg::ROW_W-1:0] top_q, top_d, cur_row_q, cur_row_d;
  logic [tcs_pkg::COL_W-1:0] cur_col_q, cur_col_d;
  logic [tcs_pkg::LINE_W-1:0] hwl_q, hwl_d;
  logic [tcs_pkg::CNT_W-1:0] hcnt_q, hcnt_d, vb_q, vb_d;
  logic [7:0] res_ch_q, res_ch_d, res_attr_q, res_attr_d;
  logic res_err_q, res_err_d, rd_hist_q, rd_hist_d;
  logic ovalid_q, ovalid_d;
  logic [6:0] o_ccol_q;
  logic [4:0] o_crow_q;
  logic [7:0] o_ch_q, o_attr_q;
  logic [8:0] o_vb_q, o_hf_q;
  logic o_err_q, o_load;

  logic [tcs_pkg::ROW_W-1:0] au_row;
  logic [tcs_pkg::COL_W-1:0] au_col;
  logic [tcs_pkg::SCR_AW-1:0] au_addr;
  logic scr_we;
  logic [tcs_pkg::SCR_AW-1:0] scr_waddr;
  logic [15:0] scr_wdata, scr_rdata, hist_rdata;
  logic hist_we;
  logic [tcs_pkg::HIST_AW-1:0] hist_waddr, hist_raddr;

  tcs_addr u_addr (
    .top_i (top_q),
    .row_i (au_row),
    .col_i (au_col),
    .addr_o(au_addr)
  );

  tcs_ram #(.WIDTH(16), .DEPTH(tcs_pkg::SCR_DEPTH)) u_scr_ram (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(scr_waddr),
    .wdata_i(scr_wdata),
    .raddr_i(au_addr),
    .rdata_o(scr_rdata)
  );

  tcs_ram #(.WIDTH(16), .DEPTH(tcs_pkg::HIST_DEPTH)) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(scr_rdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  assign in_i.ready         = (state_q == tcs_pkg::ST_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.cursor_col   = o_ccol_q;
  assign out_o.cursor_row   = o_crow_q;
  assign out_o.cell_char    = o_ch_q;
  assign out_o.cell_attr    = o_attr_q;
  assign out_o.view_offset  = o_vb_q;
  assign out_o.history_fill = o_hf_q;
  assign out_o.coord_error  = o_err_q;

  logic in_range, bs_write;
  logic [tcs_pkg::ROW_W-1:0] pr, wr_row, scr_r;
  logic [tcs_pkg::COL_W-1:0] pc, wr_col, nc;
  logic [tcs_pkg::ROW_W:0] nr;
  logic [7:0] a_eff;
  logic [tcs_pkg::CNT_W-1:0] k;
  logic [tcs_pkg::LINE_W-1:0] line;
  int line_sum;

  always_comb begin
    in_range = (int'(col_q) < tcs_pkg::COLUMNS) && (int'(row_q) < tcs_pkg::ROWS);
    a_eff    = (attr_q != 8'd0) ? attr_q : dflt_q;
    pr = atc_q ? cur_row_q : row_q[tcs_pkg::ROW_W-1:0];
    pc = atc_q ? cur_col_q : col_q[tcs_pkg::COL_W-1:0];
    wr_row   = pr;
    wr_col   = pc;
    bs_write = 1'b0;
    nr = {1'b0, pr};
    nc = pc;
    if (ch_q == tcs_pkg::CH_NEWLINE) begin
      nc = '0;
      nr = {1'b0, pr} + 1'b1;
    end else if (ch_q == tcs_pkg::CH_BACKSPACE) begin
      if (pr != '0 || pc != '0) begin
        bs_write = 1'b1;
        if (pc == '0) begin
          wr_row = pr - 1'b1;
          wr_col = tcs_pkg::COL_W'(tcs_pkg::COLUMNS - 1);
        end else begin
          wr_col = pc - 1'b1;
        end
        nr = {1'b0, wr_row};
        nc = wr_col;
      end
    end else if (int'(pc) == tcs_pkg::COLUMNS - 1) begin
      nc = '0;
      nr = {1'b0, pr} + 1'b1;
    end else begin
      nc = pc + 1'b1;
    end
    scr_r = tcs_pkg::ROW_W'(int'(row_q) - int'(vb_q));
    k     = tcs_pkg::CNT_W'(int'(vb_q) - int'(row_q));
    line_sum = int'(hwl_q) + tcs_pkg::HISTORY_LINES - int'(k);
    if (line_sum >= tcs_pkg::HISTORY_LINES) begin
      line_sum = line_sum - tcs_pkg::HISTORY_LINES;
    end
    line = tcs_pkg::LINE_W'(line_sum);
    hist_raddr = tcs_pkg::HIST_AW'(int'(line) * tcs_pkg::COLUMNS + int'(col_q));
    hist_waddr = tcs_pkg::HIST_AW'(int'(hwl_q) * tcs_pkg::COLUMNS
                 + int'(cnt_q[tcs_pkg::COL_W-1:0]));
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    zero_d    = zero_q;
    top_d     = top_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    hwl_d     = hwl_q;
    hcnt_d    = hcnt_q;
    vb_d      = vb_q;
    res_ch_d  = res_ch_q;
    res_attr_d = res_attr_q;
    res_err_d = res_err_q;
    rd_hist_d = rd_hist_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    o_load    = 1'b0;
    au_row    = row_q[tcs_pkg::ROW_W-1:0];
    au_col    = col_q[tcs_pkg::COL_W-1:0];
    scr_we    = 1'b0;
    scr_waddr = au_addr;
    scr_wdata = {dflt_q, tcs_pkg::CH_SPACE};
    hist_we   = 1'b0;
    case (state_q)
      tcs_pkg::ST_CLR: begin
        scr_we    = 1'b1;
        scr_waddr = cnt_q;
        scr_wdata = zero_q ? 16'd0 : {dflt_q, tcs_pkg::CH_SPACE};
        cnt_d     = cnt_q + 1'b1;
        if (int'(cnt_q) == tcs_pkg::SCR_DEPTH - 1) begin
          cnt_d   = '0;
          zero_d  = 1'b0;
          state_d = zero_q ? tcs_pkg::ST_IDLE : tcs_pkg::ST_FIN;
        end
      end
      tcs_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = tcs_pkg::ST_EXEC;
        end
      end
      tcs_pkg::ST_EXEC: begin
        res_ch_d   = 8'd0;
        res_attr_d = 8'd0;
        res_err_d  = 1'b0;
        state_d    = tcs_pkg::ST_FIN;
        case (func_q)
          tcs_pkg::FN_PRINT: begin
            if (!atc_q && !in_range) begin
              res_err_d = 1'b1;
            end else begin
              au_row    = wr_row;
              au_col    = wr_col;
              scr_we    = (ch_q != tcs_pkg::CH_NEWLINE)
                          && ((ch_q != tcs_pkg::CH_BACKSPACE) || bs_write);
              scr_wdata = {a_eff, (ch_q == tcs_pkg::CH_BACKSPACE) ? tcs_pkg::CH_SPACE : ch_q};
              cur_col_d = nc;
              if (int'(nr) == tcs_pkg::ROWS) begin
                cur_row_d = tcs_pkg::ROW_W'(tcs_pkg::ROWS - 1);
                cnt_d     = '0;
                state_d   = tcs_pkg::ST_SCR_RD;
              end else begin
                cur_row_d = nr[tcs_pkg::ROW_W-1:0];
              end
            end
          end
          tcs_pkg::FN_POKE: begin
            scr_we    = in_range;
            scr_wdata = {attr_q, ch_q};
          end
          tcs_pkg::FN_UP: begin
            if (int'(vb_q) < tcs_pkg::HISTORY_LINES && vb_q < hcnt_q) begin
              vb_d = vb_q + 1'b1;
            end
          end
          tcs_pkg::FN_DOWN: begin
            if (vb_q != '0) begin
              vb_d = vb_q - 1'b1;
            end
          end
          tcs_pkg::FN_CLEAR: begin
            vb_d      = '0;
            cur_row_d = '0;
            cur_col_d = '0;
            cnt_d     = '0;
            state_d   = tcs_pkg::ST_CLR;
          end
          tcs_pkg::FN_READ: begin
            if (!in_range) begin
              res_ch_d   = tcs_pkg::CH_SPACE;
              res_attr_d = dflt_q;
              res_err_d  = 1'b1;
            end else if (int'(vb_q) > int'(row_q)) begin
              if (k > hcnt_q) begin
                res_ch_d   = tcs_pkg::CH_SPACE;
                res_attr_d = dflt_q;
              end else begin
                rd_hist_d = 1'b1;
                state_d   = tcs_pkg::ST_RD_CAP;
              end
            end else begin
              au_row    = scr_r;
              rd_hist_d = 1'b0;
              state_d   = tcs_pkg::ST_RD_CAP;
            end
          end
          default: begin
          end
        endcase
      end
      tcs_pkg::ST_SCR_RD: begin
        au_row  = '0;
        au_col  = cnt_q[tcs_pkg::COL_W-1:0];
        state_d = tcs_pkg::ST_SCR_WR;
      end
      tcs_pkg::ST_SCR_WR: begin
        au_row  = '0;
        au_col  = cnt_q[tcs_pkg::COL_W-1:0];
        scr_we  = 1'b1;
        hist_we = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = tcs_pkg::ST_SCR_RD;
        if (int'(cnt_q) == tcs_pkg::COLUMNS - 1) begin
          cnt_d   = '0;
          state_d = tcs_pkg::ST_FIN;
          hwl_d   = (int'(hwl_q) == tcs_pkg::HISTORY_LINES - 1) ? '0 : hwl_q + 1'b1;
          if (int'(hcnt_q) < tcs_pkg::HISTORY_LINES) begin
            hcnt_d = hcnt_q + 1'b1;
          end
          top_d = (int'(top_q) == tcs_pkg::ROWS - 1) ? '0 : top_q + 1'b1;
        end
      end
      tcs_pkg::ST_RD_CAP: begin
        res_ch_d   = rd_hist_q ? hist_rdata[7:0] : scr_rdata[7:0];
        res_attr_d = rd_hist_q ? hist_rdata[15:8] : scr_rdata[15:8];
        state_d    = tcs_pkg::ST_FIN;
      end
      tcs_pkg::ST_FIN: begin
        if (!ovalid_q || out_o.ready) begin
          o_load   = 1'b1;
          ovalid_d = 1'b1;
          state_d  = tcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tcs_pkg::ST_CLR;
      cnt_q     <= '0;
      zero_q    <= 1'b1;
      dflt_q    <= tcs_pkg::BLANK_ATTR_RESET;
      top_q     <= '0;
      cur_row_q <= '0;
      cur_col_q <= '0;
      hwl_q     <= '0;
      hcnt_q    <= '0;
      vb_q      <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      zero_q    <= zero_d;
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
      top_q     <= top_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      hwl_q     <= hwl_d;
      hcnt_q    <= hcnt_d;
      vb_q      <= vb_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q <= in_i.func;
      ch_q   <= in_i.ch;
      attr_q <= in_i.attr;
      col_q  <= in_i.col;
      row_q  <= in_i.row;
      atc_q  <= in_i.at_cursor;
    end
    res_ch_q   <= res_ch_d;
    res_attr_q <= res_attr_d;
    res_err_q  <= res_err_d;
    rd_hist_q  <= rd_hist_d;
    if (o_load) begin
      o_ccol_q <= 7'(cur_col_q);
      o_crow_q <= 5'(cur_row_q);
      o_ch_q   <= res_ch_q;
      o_attr_q <= res_attr_q;
      o_vb_q   <= 9'(vb_q);
      o_hf_q   <= 9'(hcnt_q);
      o_err_q  <= res_err_q;
    end
  end

`ifndef SYNTHESIS
  a_cursor_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_row_q) < tcs_pkg::ROWS) else $error("cursor row out of range");
  a_view_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q <= hcnt_q) else $error("view offset beyond history");
  a_fill_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> hcnt_q >= $past(hcnt_q)) else $error("history fill decreased");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == tcs_pkg::ST_EXEC) else $error("accept lost");
`endif

endmodule

@@ tb/tb_text_console_with_scrollback.sv @@
`timescale 1ns / 100ps

module tb_text_console_with_scrollback;

  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int RANDOM_WORDS = 1600;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [8:0] view_offset;
    logic [8:0] history_fill;
    logic       coord_error;
  } console_result_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [7:0]      ch;
    logic [7:0]      attr;
    logic [6:0]      col;
    logic [5:0]      row;
    logic            at_cursor;
    logic            typed;
    console_result_t want;
  } console_op_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  tcs_in_if  in_if ();
  tcs_out_if out_if ();

  text_console_with_scrollback DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic [15:0] scr_model [tcs_pkg::SCR_DEPTH];
  logic [15:0] hist_model [tcs_pkg::HIST_DEPTH];
  int unsigned top_row;
  int unsigned cursor;
  int unsigned hist_wr_line;
  int unsigned hist_count;
  int unsigned view_back;
  logic [7:0] dflt_color;

  console_result_t pending_results [$];
  int unsigned errors;
  int unsigned cycles;
  bit quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_console_with_scrollback: mismatch");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("error: %s got %0d want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    console_result_t w;
    if (out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        w = pending_results.pop_front();
        if (out_if.cursor_col !== w.cursor_col)
          report("cursor_col", out_if.cursor_col, w.cursor_col);
        if (out_if.cursor_row !== w.cursor_row)
          report("cursor_row", out_if.cursor_row, w.cursor_row);
        if (out_if.cell_char !== w.cell_char)
          report("cell_char", out_if.cell_char, w.cell_char);
        if (out_if.cell_attr !== w.cell_attr)
          report("cell_attr", out_if.cell_attr, w.cell_attr);
        if (out_if.view_offset !== w.view_offset)
          report("view_offset", out_if.view_offset, w.view_offset);
        if (out_if.history_fill !== w.history_fill)
          report("history_fill", out_if.history_fill, w.history_fill);
        if (out_if.coord_error !== w.coord_error)
          report("coord_error", out_if.coord_error, w.coord_error);
      end
    end
    if (rst_ni) out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 27);
  end

  function automatic int unsigned phys_index(int unsigned r, int unsigned c);
    return ((top_row + r) % tcs_pkg::ROWS) * tcs_pkg::COLUMNS + c;
  endfunction

  task automatic blank_phys_row(int unsigned prow);
    for (int j = 0; j < tcs_pkg::COLUMNS; j++)
      scr_model[prow * tcs_pkg::COLUMNS + j] = {dflt_color, tcs_pkg::CH_SPACE};
  endtask

  task automatic push_top_row();
    for (int j = 0; j < tcs_pkg::COLUMNS; j++)
      hist_model[hist_wr_line * tcs_pkg::COLUMNS + j] = scr_model[top_row * tcs_pkg::COLUMNS + j];
    hist_wr_line = (hist_wr_line + 1) % tcs_pkg::HISTORY_LINES;
    if (hist_count < tcs_pkg::HISTORY_LINES) hist_count++;
    blank_phys_row(top_row);
    top_row = (top_row + 1) % tcs_pkg::ROWS;
  endtask

  task automatic console_apply(input console_op_t op, output console_result_t res);
    int unsigned off;
    int unsigned k;
    int unsigned hline;
    logic [7:0] a;
    logic [15:0] v;
    res = '0;
    a = (op.attr != 0) ? op.attr : dflt_color;
    case (op.func)
      tcs_pkg::FN_PRINT: begin
        if (!op.at_cursor && (op.col >= tcs_pkg::COLUMNS || op.row >= tcs_pkg::ROWS)) begin
          res.coord_error = 1'b1;
        end else begin
          off = op.at_cursor ? cursor % tcs_pkg::SCR_DEPTH
                             : op.row * tcs_pkg::COLUMNS + op.col;
          if (op.ch == tcs_pkg::CH_NEWLINE) begin
            off = (off / tcs_pkg::COLUMNS + 1) * tcs_pkg::COLUMNS;
          end else if (op.ch == tcs_pkg::CH_BACKSPACE) begin
            if (off > 0) begin
              off--;
              scr_model[phys_index(off / tcs_pkg::COLUMNS, off % tcs_pkg::COLUMNS)] =
                {a, tcs_pkg::CH_SPACE};
            end
          end else begin
            scr_model[phys_index(off / tcs_pkg::COLUMNS, off % tcs_pkg::COLUMNS)] = {a, op.ch};
            off++;
          end
          if (off >= tcs_pkg::SCR_DEPTH) begin
            push_top_row();
            off -= tcs_pkg::COLUMNS;
          end
          cursor = off;
        end
      end
      tcs_pkg::FN_POKE: begin
        if (op.col < tcs_pkg::COLUMNS && op.row < tcs_pkg::ROWS)
          scr_model[phys_index(op.row, op.col)] = {op.attr, op.ch};
      end
      tcs_pkg::FN_UP: begin
        if (view_back < tcs_pkg::HISTORY_LINES && view_back < hist_count) view_back++;
      end
      tcs_pkg::FN_DOWN: begin
        if (view_back > 0) view_back--;
      end
      tcs_pkg::FN_CLEAR: begin
        for (int r = 0; r < tcs_pkg::ROWS; r++) blank_phys_row(r);
        view_back = 0;
        cursor = 0;
      end
      tcs_pkg::FN_READ: begin
        if (op.col >= tcs_pkg::COLUMNS || op.row >= tcs_pkg::ROWS) begin
          res.cell_char = tcs_pkg::CH_SPACE;
          res.cell_attr = dflt_color;
          res.coord_error = 1'b1;
        end else begin
          if (view_back > op.row) begin
            k = view_back - op.row;
            if (k > hist_count) begin
              v = {dflt_color, tcs_pkg::CH_SPACE};
            end else begin
              hline = (hist_wr_line + tcs_pkg::HISTORY_LINES - k) % tcs_pkg::HISTORY_LINES;
              v = hist_model[hline * tcs_pkg::COLUMNS + op.col];
            end
          end else begin
            v = scr_model[phys_index(op.row - view_back, op.col)];
          end
          res.cell_char = v[7:0];
          res.cell_attr = v[15:8];
        end
      end
      default: ;
    endcase
    res.cursor_col = 7'(cursor % tcs_pkg::COLUMNS);
    res.cursor_row = 5'(cursor / tcs_pkg::COLUMNS);
    res.view_offset = 9'(view_back);
    res.history_fill = 9'(hist_count);
  endtask

  task automatic send_word(input console_op_t op);
    console_result_t res;
    int gap;
    if (!quiet && $urandom_range(99) < 27) begin
      gap = $urandom_range(6, 1);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= op.func;
    in_if.ch        <= op.ch;
    in_if.attr      <= op.attr;
    in_if.col       <= op.col;
    in_if.row       <= op.row;
    in_if.at_cursor <= op.at_cursor;
    do @(posedge clk_i); while (!in_if.ready);
    console_apply(op, res);
    pending_results.push_back(op.typed ? op.want : res);
  endtask

  task automatic drain_and_set_color(input logic [7:0] color);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dflt_color = color;
  endtask

  function automatic console_op_t make_op(logic [2:0] f, logic [7:0] c, logic [7:0] a,
                                          logic [6:0] cl, logic [5:0] rw, logic atc);
    console_op_t op;
    op = '0;
    op.func = f; op.ch = c; op.attr = a; op.col = cl; op.row = rw; op.at_cursor = atc;
    return op;
  endfunction

  function automatic console_op_t random_op();
    int pick;
    logic [7:0] c;
    logic [7:0] a;
    logic [6:0] cl;
    logic [5:0] rw;
    logic atc;
    pick = $urandom_range(99);
    c   = 8'($urandom_range(255));
    a   = 8'($urandom_range(255));
    cl  = 7'($urandom_range(127));
    rw  = 6'($urandom_range(63));
    atc = 1'($urandom_range(1));
    if (pick < 45) begin
      if ($urandom_range(2) == 0) c = tcs_pkg::CH_NEWLINE;
      else if ($urandom_range(19) == 0) c = tcs_pkg::CH_BACKSPACE;
      return make_op(tcs_pkg::FN_PRINT, c, a, cl, rw, 1'b1);
    end
    if (pick < 55) begin
      if ($urandom_range(3) != 0) begin
        cl = 7'($urandom_range(tcs_pkg::COLUMNS - 1));
        rw = 6'($urandom_range(tcs_pkg::ROWS - 1));
      end
      return make_op(tcs_pkg::FN_PRINT, c, a, cl, rw, 1'b0);
    end
    if (pick < 65)
      return make_op(tcs_pkg::FN_POKE, c, a, 7'($urandom_range(90)), 6'($urandom_range(30)),
                     atc);
    if (pick < 75) return make_op(tcs_pkg::FN_UP, c, a, cl, rw, atc);
    if (pick < 80) return make_op(tcs_pkg::FN_DOWN, c, a, cl, rw, atc);
    if (pick < 82) return make_op(tcs_pkg::FN_CLEAR, c, a, cl, rw, atc);
    if (pick < 97) begin
      if ($urandom_range(7) != 0) begin
        cl = 7'($urandom_range(tcs_pkg::COLUMNS - 1));
        rw = 6'($urandom_range(tcs_pkg::ROWS - 1));
      end
      return make_op(tcs_pkg::FN_READ, c, a, cl, rw, atc);
    end
    return make_op(($urandom_range(1) != 0) ? FN_SPARE7 : FN_SPARE6, c, a, cl, rw, atc);
  endfunction

  console_op_t directed [$];

  initial begin
    console_op_t op;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.func = tcs_pkg::FN_PRINT;
    in_if.ch = '0;
    in_if.attr = '0;
    in_if.col = '0;
    in_if.row = '0;
    in_if.at_cursor = 1'b0;
    out_if.ready = 1'b0;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    foreach (scr_model[i]) scr_model[i] = '0;
    foreach (hist_model[i]) hist_model[i] = '0;
    top_row = 0; cursor = 0; hist_wr_line = 0; hist_count = 0; view_back = 0;
    dflt_color = tcs_pkg::BLANK_ATTR_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    op = make_op(tcs_pkg::FN_READ, 8'd0, 8'd0, 7'd0, 6'd0, 1'b0); op.typed = 1'b1;
    directed.push_back(op);
    op = make_op(tcs_pkg::FN_READ, 8'd0, 8'd0, 7'd80, 6'd0, 1'b0); op.typed = 1'b1;
    op.want.cell_char = tcs_pkg::CH_SPACE; op.want.cell_attr = tcs_pkg::BLANK_ATTR_RESET;
    op.want.coord_error = 1'b1;
    directed.push_back(op);
    op = make_op(tcs_pkg::FN_READ, 8'd0, 8'd0, 7'd0, 6'd25, 1'b0); op.typed = 1'b1;
    op.want.cell_char = tcs_pkg::CH_SPACE; op.want.cell_attr = tcs_pkg::BLANK_ATTR_RESET;
    op.want.coord_error = 1'b1;
    directed.push_back(op);
    op = make_op(tcs_pkg::FN_PRINT, 8'hFF, 8'hFF, 7'd127, 6'd63, 1'b0); op.typed = 1'b1;
    op.want.coord_error = 1'b1;
    directed.push_back(op);
    directed.push_back(make_op(tcs_pkg::FN_PRINT, 8'd65, 8'd0, 7'd0, 6'd0, 1'b1));
    directed.push_back(make_op(tcs_pkg::FN_PRINT, 8'hFF, 8'hFF, 7'd0, 6'd0, 1'b1));
    directed.push_back(make_op(tcs_pkg::FN_PRINT, tcs_pkg::CH_BACKSPACE, 8'h21, 7'd0, 6'd0,
                               1'b1));
    directed.push_back(make_op(tcs_pkg::FN_PRINT, tcs_pkg::CH_NEWLINE, 8'd0, 7'd0, 6'd0, 1'b1));
    directed.push_back(make_op(tcs_pkg::FN_PRINT, 8'd66, 8'd0, 7'd79, 6'd24, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_PRINT, tcs_pkg::CH_NEWLINE, 8'd0, 7'd5, 6'd24,
                               1'b0));
    directed.push_back(make_op(tcs_pkg::FN_UP, 8'd0, 8'd0, 7'd0, 6'd0, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_UP, 8'd0, 8'd0, 7'd0, 6'd0, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_UP, 8'd0, 8'd0, 7'd0, 6'd0, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_READ, 8'd0, 8'd0, 7'd79, 6'd0, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_READ, 8'd0, 8'd0, 7'd0, 6'd1, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_POKE, 8'h7E, 8'h00, 7'd79, 6'd24, 1'b1));
    directed.push_back(make_op(tcs_pkg::FN_POKE, 8'h7E, 8'hC3, 7'd80, 6'd24, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_READ, 8'd0, 8'd0, 7'd79, 6'd24, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_DOWN, 8'd0, 8'd0, 7'd0, 6'd0, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_DOWN, 8'd0, 8'd0, 7'd0, 6'd0, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_DOWN, 8'd0, 8'd0, 7'd0, 6'd0, 1'b0));
    directed.push_back(make_op(FN_SPARE6, 8'hFF, 8'hFF, 7'd127, 6'd63, 1'b1));
    directed.push_back(make_op(FN_SPARE7, 8'hFF, 8'hFF, 7'd127, 6'd63, 1'b1));
    directed.push_back(make_op(tcs_pkg::FN_CLEAR, 8'd0, 8'd0, 7'd0, 6'd0, 1'b0));
    directed.push_back(make_op(tcs_pkg::FN_PRINT, tcs_pkg::CH_BACKSPACE, 8'd0, 7'd0, 6'd0,
                               1'b1));
    foreach (directed[i]) send_word(directed[i]);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) drain_and_set_color(8'd0);
      if (n == 700) drain_and_set_color(8'd255);
      if (n == 1100) drain_and_set_color(8'($urandom_range(255)));
      if (n == 1400) drain_and_set_color(tcs_pkg::BLANK_ATTR_RESET);
      quiet = (n >= 400 && n < 650);
      send_word(random_op());
    end
    in_if.valid <= 1'b0;
    quiet = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("text_console_with_scrollback: match");
    else $display("text_console_with_scrollback: mismatch");
    $finish;
  end

endmodule
